[hdl/slst_pkg.sv]
// shared types and constants of the sample level to speaker tone block
// no dependencies

package slst_pkg;

    localparam int SMP_W   = 16;
    localparam int THR_W   = 16;
    localparam int BASE_W  = 16;
    localparam int SHIFT_W = 4;
    localparam int CLK_W   = 24;
    localparam int LVL_W   = 16;
    localparam int FRQ_W   = 17;
    localparam int DIV_W   = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 2;
    localparam int ADDR_W  = IDX_W + 2;

    localparam logic [THR_W-1:0]   THR_RST   = THR_W'(64);
    localparam logic [BASE_W-1:0]  BASE_RST  = BASE_W'(220);
    localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(5);
    localparam logic [CLK_W-1:0]   CLK_RST   = CLK_W'(1193182);

    localparam logic [IDX_W-1:0] REG_THR   = 2'd0;
    localparam logic [IDX_W-1:0] REG_BASE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SHIFT = 2'd2;
    localparam logic [IDX_W-1:0] REG_CLK   = 2'd3;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_LVL,
        ST_FRQ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [THR_W-1:0]   thr;
        logic [BASE_W-1:0]  base;
        logic [SHIFT_W-1:0] shift;
        logic [CLK_W-1:0]   clk;
    } t_cfg;

    typedef struct packed {
        logic in_ready;
        logic start_lvl;
        logic start_frq;
        logic set_off;
        logic set_on;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic fire_last;
        logic batch_void;
        logic div_done;
        logic lvl_quiet;
        logic out_free;
    } t_sts;

endpackage

[hdl/slst_ifs.sv]
// valid/ready channel interfaces for samples and tone results
// depends on slst_pkg

interface slst_smp_if;
    import slst_pkg::*;
    logic              valid;
    logic              ready;
    logic signed [SMP_W-1:0] sample;
    logic              last_of_batch;
    logic              batch_empty;

    modport source (output valid, output sample, output last_of_batch,
                    output batch_empty, input ready);
    modport sink   (input valid, input sample, input last_of_batch,
                    input batch_empty, output ready);
endinterface

interface slst_tone_if;
    import slst_pkg::*;
    logic             valid;
    logic             ready;
    logic             speaker_on;
    logic [DIV_W-1:0] divisor;

    modport source (output valid, output speaker_on, output divisor, input ready);
    modport sink   (input valid, input speaker_on, input divisor, output ready);
endinterface

[hdl/slst_div.sv]
// iterative restoring divider, one quotient bit per cycle
// no dependencies, no slst_pkg types used

module slst_div #(
    parameter int DVD_W = 25,
    parameter int DVS_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = !w_diff[DVS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/slst_dp.sv]
// datapath: level accumulators, shared divider, result staging and output register
// depends on slst_pkg and slst_div

module slst_dp #(
    parameter int MAX_BATCH = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  slst_pkg::t_cfg              i_cfg,
    input  slst_pkg::t_cmd              i_cmd,
    output slst_pkg::t_sts              o_sts,
    input  logic                        i_valid,
    input  logic signed [slst_pkg::SMP_W-1:0] i_sample,
    input  logic                        i_last,
    input  logic                        i_empty,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_speaker_on,
    output logic [slst_pkg::DIV_W-1:0]  o_divisor
);
    import slst_pkg::*;

    localparam int CNT_W = $clog2(MAX_BATCH + 1);
    localparam int SUM_W = 15 + CNT_W;
    localparam int DVD_W = (SUM_W > CLK_W) ? SUM_W : CLK_W;
    localparam int DVS_W = (CNT_W > FRQ_W) ? CNT_W : FRQ_W;

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_cnt;
    logic [SMP_W-1:0] w_mag;
    logic             w_add;
    logic             w_fire;

    logic             w_div_start;
    logic [DVD_W-1:0] w_dvd;
    logic [DVS_W-1:0] w_dvs;
    logic             w_div_done;
    logic [DVD_W-1:0] w_quo;
    logic [LVL_W-1:0] w_lvl;
    logic [FRQ_W-1:0] w_frq;
    logic [DIV_W-1:0] w_clamp;

    logic             r_pend_on;
    logic [DIV_W-1:0] r_pend_div;
    logic             r_out_valid;
    logic             r_out_on;
    logic [DIV_W-1:0] r_out_div;

    assign w_fire = i_valid && i_cmd.in_ready;
    assign w_mag  = i_sample[SMP_W-1] ? SMP_W'(~i_sample + 1'b1) : SMP_W'(i_sample);
    assign w_add  = !i_empty && (r_cnt < CNT_W'(MAX_BATCH));
    assign n_sum  = w_add ? r_sum + SUM_W'(w_mag) : r_sum;
    assign n_cnt  = w_add ? r_cnt + CNT_W'(1) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (w_fire) begin
            if (i_last) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

    // level = sum / count, then freq for the timer division
    assign w_lvl = w_quo[LVL_W-1:0];
    assign w_frq = {1'b0, i_cfg.base} + FRQ_W'(w_lvl >> i_cfg.shift);

    assign w_div_start = i_cmd.start_lvl || i_cmd.start_frq;
    assign w_dvd = i_cmd.start_lvl ? DVD_W'(n_sum) : DVD_W'(i_cfg.clk);
    assign w_dvs = i_cmd.start_lvl ? DVS_W'(n_cnt) : DVS_W'(w_frq);

    slst_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        if (|w_quo[DVD_W-1:DIV_W]) begin
            w_clamp = {DIV_W{1'b1}};
        end else if (w_quo[DIV_W-1:0] == '0) begin
            w_clamp = DIV_W'(1);
        end else begin
            w_clamp = w_quo[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_off) begin
            r_pend_on  <= 1'b0;
            r_pend_div <= '0;
        end else if (i_cmd.set_on) begin
            r_pend_on  <= 1'b1;
            r_pend_div <= w_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_on  <= r_pend_on;
            r_out_div <= r_pend_div;
        end
    end

    assign o_sts.fire_last  = w_fire && i_last;
    assign o_sts.batch_void = i_empty || (n_cnt == '0);
    assign o_sts.div_done   = w_div_done;
    assign o_sts.lvl_quiet  = (w_lvl < i_cfg.thr) || (w_frq == '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_speaker_on = r_out_on;
    assign o_divisor    = r_out_div;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BATCH))
        else $error("sample count above batch limit");

    a_on_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_on |=> r_pend_div != '0)
        else $error("speaker on with zero divisor");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.emit) && !r_out_on |-> r_out_div == '0)
        else $error("speaker off with nonzero divisor");

endmodule

[hdl/slst_ctrl.sv]
// controller: sequences accumulation, the two divisions and result hand-off
// depends on slst_pkg

module slst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  slst_pkg::t_sts i_sts,
    output slst_pkg::t_cmd o_cmd
);
    import slst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACC: begin
                if (i_sts.fire_last) begin
                    n_state = i_sts.batch_void ? ST_EMIT : ST_LVL;
                end
            end
            ST_LVL: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.lvl_quiet ? ST_EMIT : ST_FRQ;
                end
            end
            ST_FRQ: begin
                if (i_sts.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_ACC: begin
                o_cmd.in_ready  = 1'b1;
                o_cmd.set_off   = i_sts.fire_last && i_sts.batch_void;
                o_cmd.start_lvl = i_sts.fire_last && !i_sts.batch_void;
            end
            ST_LVL: begin
                o_cmd.set_off   = i_sts.div_done && i_sts.lvl_quiet;
                o_cmd.start_frq = i_sts.div_done && !i_sts.lvl_quiet;
            end
            ST_FRQ: begin
                o_cmd.set_on = i_sts.div_done;
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_LVL || r_state == ST_FRQ))
        else $error("divider finished outside a division state");

    a_emit_then_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == ST_ACC)
        else $error("result hand-off did not return to accumulation");

    a_start_leaves_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_lvl |=> r_state == ST_LVL && !o_cmd.in_ready)
        else $error("level division started without holding input");

endmodule

[hdl/sample_level_to_speaker_tone.sv]
// top level of the sample level to speaker tone block: register file and wiring
// depends on slst_pkg, slst_ifs, slst_ctrl, slst_dp

// Samples arrive on i_sample_ch; each item adds the magnitude of its sample to a
// running level sum unless batch_empty is set or the batch already holds
// MAX_BATCH samples. The item with last_of_batch produces one result on
// o_tone_ch: speaker_on and the timer divisor, or off with divisor 0 when the
// batch was empty, mean level is below silence_threshold or the frequency is 0.
// Items without last_of_batch are taken one per cycle. After a last item the
// input is held off while one shared divider, one quotient bit per cycle,
// forms level = sum / count and then divisor = timer_clock / frequency: the
// divider width W is max(15 + clog2(MAX_BATCH + 1), 24), 25 at the default.
// An audible batch runs both divisions before the next item is taken, a
// silent one only the first, an empty one none.
// The result sits in an output register; a stalled receiver holds it, and the
// block goes on with the next batch until a further result has to wait.
// Reset clears the accumulators, the output valid and loads the register
// defaults. The APB port holds four registers at byte addresses 0, 4, 8, 12
// and should only be written while the block is idle.

module sample_level_to_speaker_tone #(
    parameter int MAX_BATCH = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    slst_smp_if.sink                      i_sample_ch,
    slst_tone_if.source                   o_tone_ch,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [slst_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [slst_pkg::DATA_W-1:0]   i_pwdata,
    output logic [slst_pkg::DATA_W-1:0]   o_prdata,
    output logic                          o_pready
);
    import slst_pkg::*;

    t_cfg             r_cfg;
    t_cmd             w_cmd;
    t_sts             w_sts;
    logic             w_wr;
    logic [IDX_W-1:0] w_idx;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;
    assign w_idx    = i_paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr   <= THR_RST;
            r_cfg.base  <= BASE_RST;
            r_cfg.shift <= SHIFT_RST;
            r_cfg.clk   <= CLK_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_THR:   r_cfg.thr   <= i_pwdata[THR_W-1:0];
                REG_BASE:  r_cfg.base  <= i_pwdata[BASE_W-1:0];
                REG_SHIFT: r_cfg.shift <= i_pwdata[SHIFT_W-1:0];
                REG_CLK:   r_cfg.clk   <= i_pwdata[CLK_W-1:0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_THR:   o_prdata = DATA_W'(r_cfg.thr);
            REG_BASE:  o_prdata = DATA_W'(r_cfg.base);
            REG_SHIFT: o_prdata = DATA_W'(r_cfg.shift);
            REG_CLK:   o_prdata = DATA_W'(r_cfg.clk);
            default:   o_prdata = '0;
        endcase
    end

    assign i_sample_ch.ready = w_cmd.in_ready;

    slst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    slst_dp #(
        .MAX_BATCH (MAX_BATCH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_valid      (i_sample_ch.valid),
        .i_sample     (i_sample_ch.sample),
        .i_last       (i_sample_ch.last_of_batch),
        .i_empty      (i_sample_ch.batch_empty),
        .i_out_ready  (o_tone_ch.ready),
        .o_out_valid  (o_tone_ch.valid),
        .o_speaker_on (o_tone_ch.speaker_on),
        .o_divisor    (o_tone_ch.divisor)
    );

endmodule

[tb/sample_level_to_speaker_tone_tb.sv]
// testbench for sample_level_to_speaker_tone: drives sample batches and register writes,
// predicts each tone result and checks it field by field in a small scoreboard
// depends on slst_pkg, slst_ifs and the block itself

module sample_level_to_speaker_tone_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slst_pkg::*;

    localparam int MAX_BATCH   = 512;
    localparam int SETTLE      = 80;
    localparam int HOLD_CYCLES = 500;
    localparam int LIMIT       = 800000;

    typedef struct packed {
        logic             speaker_on;
        logic [DIV_W-1:0] divisor;
    } t_tone;

    class t_tone_scoreboard;
        t_cfg        cfg;
        logic [24:0] level_sum;
        logic [9:0]  sample_count;
        t_tone       tone_q[$];
        int          errors;

        function new();
            cfg          = '{thr: THR_RST, base: BASE_RST, shift: SHIFT_RST, clk: CLK_RST};
            level_sum    = '0;
            sample_count = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_THR:   cfg.thr   = value[THR_W-1:0];
                REG_BASE:  cfg.base  = value[BASE_W-1:0];
                REG_SHIFT: cfg.shift = value[SHIFT_W-1:0];
                default:   cfg.clk   = value[CLK_W-1:0];
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(logic [IDX_W-1:0] idx);
            case (idx)
                REG_THR:   return DATA_W'(cfg.thr);
                REG_BASE:  return DATA_W'(cfg.base);
                REG_SHIFT: return DATA_W'(cfg.shift);
                default:   return DATA_W'(cfg.clk);
            endcase
        endfunction

        function int pending();
            return tone_q.size();
        endfunction

        function void note_sample(logic signed [SMP_W-1:0] s, bit last, bit empty);
            int               v;
            logic [16:0]      mag;
            logic [LVL_W-1:0] level;
            logic [FRQ_W-1:0] freq;
            logic [CLK_W-1:0] quot;
            bit               void_batch;
            t_tone            t;
            v   = s;
            mag = 17'(v < 0 ? -v : v);
            if (!empty && sample_count < MAX_BATCH) begin
                level_sum    = level_sum + 25'(mag);
                sample_count = sample_count + 10'd1;
            end
            if (!last) return;
            void_batch   = empty || sample_count == 0;
            level        = void_batch ? '0 : LVL_W'(level_sum / sample_count);
            level_sum    = '0;
            sample_count = '0;
            t.speaker_on = 1'b0;
            t.divisor    = '0;
            if (!void_batch && level >= cfg.thr) begin
                freq = FRQ_W'(cfg.base) + FRQ_W'(level >> cfg.shift);
                if (freq != 0) begin
                    quot         = cfg.clk / freq;
                    t.speaker_on = 1'b1;
                    if (quot > 24'hFFFF)
                        t.divisor = 16'hFFFF;
                    else if (quot == 0)
                        t.divisor = 16'd1;
                    else
                        t.divisor = quot[DIV_W-1:0];
                end
            end
            tone_q.push_back(t);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_tone(logic on, logic [DIV_W-1:0] div);
            t_tone t;
            if (tone_q.size() == 0) begin
                report($sformatf("tone on=%0b div=%0d with none expected", on, div));
                return;
            end
            t = tone_q.pop_front();
            if (on !== t.speaker_on)
                report($sformatf("speaker_on %0b, expected %0b", on, t.speaker_on));
            if (div !== t.divisor)
                report($sformatf("divisor %0d, expected %0d", div, t.divisor));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_psel;
    logic i_penable;
    logic i_pwrite;
    logic [ADDR_W-1:0] i_paddr;
    logic [DATA_W-1:0] i_pwdata;
    logic [DATA_W-1:0] o_prdata;
    logic o_pready;

    slst_smp_if  smp_ch();
    slst_tone_if tone_ch();

    t_tone_scoreboard sb = new();
    int idle_pct  = 25;
    bit hold_req  = 0;
    int items_sent = 0;
    int cycles    = 0;

    sample_level_to_speaker_tone #(
        .MAX_BATCH(MAX_BATCH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample_ch(smp_ch),
        .o_tone_ch  (tone_ch),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // tone receiver with random stalls and one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 0;
                tone_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                tone_ch.ready <= ($urandom_range(99) >= idle_pct);
                @(posedge i_clk);
                if (tone_ch.valid === 1'b1 && tone_ch.ready === 1'b1)
                    sb.check_tone(tone_ch.speaker_on, tone_ch.divisor);
            end
        end
    end

    task automatic reg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        i_psel    <= 1'b1;
        i_pwrite  <= 1'b1;
        i_penable <= 1'b0;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (o_pready !== 1'b1);
        sb.set_reg(idx, value);
        // read back through the same port
        i_pwrite  <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (o_pready !== 1'b1);
        if (o_prdata !== sb.reg_value(idx))
            sb.report($sformatf("register %0d reads %0h, expected %0h",
                                idx, o_prdata, sb.reg_value(idx)));
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_and_settle();
        smp_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [THR_W-1:0] thr, logic [BASE_W-1:0] base,
                                 logic [SHIFT_W-1:0] shift, logic [CLK_W-1:0] clk);
        drain_and_settle();
        reg_write(REG_THR, DATA_W'(thr));
        reg_write(REG_BASE, DATA_W'(base));
        reg_write(REG_SHIFT, DATA_W'(shift));
        reg_write(REG_CLK, DATA_W'(clk));
    endtask

    task automatic random_setting();
        logic [THR_W-1:0]   thr;
        logic [BASE_W-1:0]  base;
        logic [CLK_W-1:0]   clk;
        int r;
        r = $urandom_range(99);
        if (r < 30)      thr = THR_W'($urandom_range(300));
        else if (r < 50) thr = THR_W'($urandom_range(32768));
        else if (r < 58) thr = '0;
        else if (r < 62) thr = 16'hFFFF;
        else             thr = THR_W'($urandom_range(3000));
        r = $urandom_range(99);
        if (r < 10)      base = '0;
        else if (r < 20) base = 16'hFFFF;
        else             base = BASE_W'($urandom_range(1, 3000));
        r = $urandom_range(99);
        if (r < 10)      clk = '0;
        else if (r < 20) clk = 24'hFFFFFF;
        else if (r < 50) clk = CLK_RST;
        else             clk = CLK_W'($urandom);
        apply_setting(thr, base, SHIFT_W'($urandom_range(15)), clk);
    endtask

    task automatic send_item(logic signed [SMP_W-1:0] s, bit last, bit empty);
        int gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 2);
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_ch.valid         <= 1'b1;
        smp_ch.sample        <= s;
        smp_ch.last_of_batch <= last;
        smp_ch.batch_empty   <= empty;
        do @(posedge i_clk); while (smp_ch.ready !== 1'b1);
        sb.note_sample(s, last, empty);
        items_sent++;
    endtask

    function automatic logic signed [SMP_W-1:0] pick_sample(int kind);
        case (kind)
            0: return SMP_W'($urandom);
            1: return SMP_W'(int'($urandom_range(400)) - 200);
            2: begin
                case ($urandom_range(4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh8001;
                    3:       return '0;
                    default: return '1;
                endcase
            end
            default: begin
                if ($urandom_range(1))
                    return SMP_W'($urandom_range(4000));
                return SMP_W'(-int'($urandom_range(4000)));
            end
        endcase
    endfunction

    task automatic send_batch(int len, int kind, int empty_pct);
        for (int i = 0; i < len; i++)
            send_item(pick_sample(kind), i == len - 1, $urandom_range(99) < empty_pct);
    endtask

    task automatic run_random_phase(int target);
        int start;
        int r;
        start = items_sent;
        while (items_sent - start < target) begin
            r = $urandom_range(99);
            if (r < 6)
                send_item(pick_sample(0), 1'b1, 1'b1);
            else if (r < 14)
                send_batch($urandom_range(1, 6), $urandom_range(3), 50);
            else
                send_batch($urandom_range(1, 16), $urandom_range(3), 3);
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        i_psel               <= 1'b0;
        i_penable            <= 1'b0;
        i_pwrite             <= 1'b0;
        i_paddr              <= '0;
        i_pwdata             <= '0;
        smp_ch.valid         <= 1'b0;
        smp_ch.sample        <= '0;
        smp_ch.last_of_batch <= 1'b0;
        smp_ch.batch_empty   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults, empty batches, threshold edges, most negative sample
        apply_setting(THR_RST, BASE_RST, SHIFT_RST, CLK_RST);
        send_item(16'sh7FFF, 1'b1, 1'b1);
        send_item(16'sh8000, 1'b1, 1'b0);
        send_item(16'sh7FFF, 1'b0, 1'b0);
        send_item(16'sh0000, 1'b1, 1'b1);
        send_item(-16'sd1, 1'b0, 1'b0);
        send_item(16'sd1, 1'b1, 1'b0);
        send_item(16'sd1000, 1'b0, 1'b1);
        send_item(-16'sd2000, 1'b0, 1'b0);
        send_item(16'sd3000, 1'b1, 1'b0);
        send_item(16'sd0, 1'b1, 1'b0);
        send_item(16'sd63, 1'b0, 1'b0);
        send_item(16'sd64, 1'b1, 1'b0);
        send_item(16'sd64, 1'b1, 1'b0);

        // zero frequency and zero clock
        apply_setting('0, '0, 4'd15, '0);
        send_item(16'sd0, 1'b1, 1'b0);
        send_item(16'sh8000, 1'b1, 1'b0);
        send_item(16'sd5, 1'b1, 1'b1);

        apply_setting(16'd32768, 16'hFFFF, 4'd0, 24'hFFFFFF);
        send_item(16'sh8000, 1'b1, 1'b0);
        send_item(16'sh7FFF, 1'b1, 1'b0);

        // divisor clamped high
        apply_setting('0, 16'd1, 4'd15, 24'hFFFFFF);
        send_item(16'sd0, 1'b1, 1'b0);

        for (int p = 0; p < 8; p++) begin
            random_setting();
            idle_pct = (p == 2) ? 0 : 25;
            if (p == 3)
                hold_req = 1;
            if (p == 5)
                send_batch($urandom_range(MAX_BATCH + 1, MAX_BATCH + 90), 0, 0);
            run_random_phase(80);
        end

        drain_and_settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
